### hdl/chlg_pkg.sv
// ============================================================================
// chlg_pkg: shared types and constants of the core hotplug load governor
// Holds the item structs, register indexes, action codes and FSM states.
// ============================================================================
`default_nettype none

package chlg_pkg;

    localparam int NUM_CORES       = 4;
    localparam int LOAD_W          = 7;
    localparam int MASK_W          = 4;
    localparam int IDX_W           = $clog2(NUM_CORES);
    localparam int CNT_W           = $clog2(NUM_CORES + 1);
    localparam int SUM_W           = LOAD_W + IDX_W;
    localparam int DIV_STEP_W      = $clog2(SUM_W + 1);
    localparam int DOWN_CNT_W      = 4;
    localparam int UP_CNT_W        = 2;
    localparam int CFG_DATA_W      = 7;
    localparam int CFG_INDEX_W     = 2;

    localparam logic [DOWN_CNT_W-1:0] DOWN_WAIT_TICKS = DOWN_CNT_W'(10);
    localparam logic [UP_CNT_W-1:0]   UP_WAIT_TICKS   = UP_CNT_W'(2);

    localparam logic [LOAD_W-1:0] THRESHOLD_RESET = LOAD_W'(25);
    localparam logic [2:0]        MIN_CORES_RESET = 3'd2;

    localparam logic [NUM_CORES-1:0] ALL_CORES = {NUM_CORES{1'b1}};

    localparam logic [CFG_INDEX_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN_CORES = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_ENABLE    = 2'd2;

    localparam logic [1:0] ACT_NONE   = 2'd0;
    localparam logic [1:0] ACT_UP     = 2'd1;
    localparam logic [1:0] ACT_DOWN   = 2'd2;
    localparam logic [1:0] ACT_ALL_UP = 2'd3;

    localparam logic [0:0] CMD_TICK = 1'b0;

    typedef struct packed {
        logic              command;
        logic [LOAD_W-1:0] load_core0;
        logic [LOAD_W-1:0] load_core1;
        logic [LOAD_W-1:0] load_core2;
        logic [LOAD_W-1:0] load_core3;
    } in_item_t;

    typedef struct packed {
        logic [MASK_W-1:0] online_mask;
        logic [LOAD_W-1:0] average_load;
        logic [1:0]        action;
        logic [1:0]        changed_core;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_START,
        ST_DIV,
        ST_DECIDE,
        ST_DONE
    } state_t;

    function automatic logic [LOAD_W-1:0] load_sel(input in_item_t it,
                                                   input logic [IDX_W-1:0] idx);
        logic [LOAD_W-1:0] val;
        case (idx)
            2'd0:    val = it.load_core0;
            2'd1:    val = it.load_core1;
            2'd2:    val = it.load_core2;
            2'd3:    val = it.load_core3;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

### hdl/chlg_div.sv
// ============================================================================
// chlg_div: iterative restoring divider
// Divides the load sum by the online count, one quotient bit per cycle.
// ============================================================================
`default_nettype none

module chlg_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      start,
    input  wire logic [chlg_pkg::SUM_W-1:0] dividend,
    input  wire logic [chlg_pkg::CNT_W-1:0] divisor,
    output logic                           done,
    output logic [chlg_pkg::SUM_W-1:0]     quotient
);
    import chlg_pkg::*;

    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic [SUM_W-1:0]      quo_reg, quo_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W:0]        trial;
    logic [CNT_W:0]        diff;

    assign trial = {rem_reg, quo_reg[SUM_W-1]};
    assign diff  = trial - {1'b0, divisor};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = '0;
            quo_next  = dividend;
            step_next = DIV_STEP_W'(SUM_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, divisor}) begin
                rem_next = diff[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[CNT_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], 1'b0};
            end
            step_next = step_reg - 1'b1;
            if (step_reg == DIV_STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### hdl/cpu_hotplug_load_governor.sv
// ============================================================================
// cpu_hotplug_load_governor: core hotplug decision block
// Keeps the online core mask and hold counters, averages online loads and
// brings at most one core up or down per enabled tick; commands bring all up.
// ============================================================================
//
//  Channel   Ports                           Direction  Content
//  input     s_valid, s_ready, s_item        in         command and core loads
//  result    m_valid, m_ready, m_item        out        mask, average, action
//  config    cfg_valid, cfg_ready,           in         register index and data
//            cfg_index, cfg_data
//
//  An enabled tick goes from its acceptance through the sum state, which adds
//  the online loads one core at a time through one adder, a start state for the
//  bit-serial divider and the divide state until its done flag, then a decision
//  state and an output state. Commands and disabled ticks go straight to output.
//  Reset is synchronous and active low; it puts every core online.
//  The result waits in an output register while m_ready is low; the next item
//  is accepted once the previous result has moved into that register.
//
`default_nettype none

module cpu_hotplug_load_governor (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire chlg_pkg::in_item_t                s_item,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output chlg_pkg::out_item_t                    m_item,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [chlg_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [chlg_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import chlg_pkg::*;

    state_t                state_reg, state_next;
    in_item_t              item_reg, item_next;
    logic [NUM_CORES-1:0]  mask_reg, mask_next;
    logic [DOWN_CNT_W-1:0] down_reg, down_next;
    logic [UP_CNT_W-1:0]   up_reg, up_next;
    logic [LOAD_W-1:0]     thr_reg, thr_next;
    logic [2:0]            minc_reg, minc_next;
    logic                  en_reg, en_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    out_item_t             res_reg, res_next;
    out_item_t             m_item_reg, m_item_next;
    logic                  m_valid_reg, m_valid_next;

    logic                  div_start;
    logic                  div_done;
    logic [SUM_W-1:0]      div_quo;
    logic [LOAD_W-1:0]     avg;
    logic                  up_found, dn_found;
    logic [IDX_W-1:0]      up_idx, dn_idx;

    chlg_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (cnt_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign avg = (cnt_reg == '0) ? '0 : div_quo[LOAD_W-1:0];

    always_comb begin
        up_found = 1'b0;
        dn_found = 1'b0;
        up_idx   = '0;
        dn_idx   = '0;
        for (int i = NUM_CORES - 1; i >= 1; i--) begin
            if (!mask_reg[i]) begin
                up_found = 1'b1;
                up_idx   = IDX_W'(i);
            end
            if (mask_reg[i]) begin
                dn_found = 1'b1;
                dn_idx   = IDX_W'(i);
            end
        end
    end

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        mask_next    = mask_reg;
        down_next    = down_reg;
        up_next      = up_reg;
        thr_next     = thr_reg;
        minc_next    = minc_reg;
        en_next      = en_reg;
        sum_next     = sum_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        res_next     = res_reg;
        m_item_next  = m_item_reg;
        m_valid_next = m_valid_reg;
        div_start    = 1'b0;
        s_ready      = (state_reg == ST_IDLE);
        cfg_ready    = 1'b1;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            case (cfg_index)
                CFG_THRESHOLD: begin
                    thr_next = cfg_data[LOAD_W-1:0];
                end
                CFG_MIN_CORES: begin
                    minc_next = cfg_data[2:0];
                    mask_next = ALL_CORES;
                    down_next = '0;
                end
                CFG_ENABLE: begin
                    if (en_reg && !cfg_data[0]) begin
                        mask_next = ALL_CORES;
                        down_next = '0;
                    end
                    en_next = cfg_data[0];
                end
                default: begin
                end
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next = s_item;
                    if (s_item.command != CMD_TICK) begin
                        mask_next = ALL_CORES;
                        down_next = '0;
                        res_next  = '{online_mask: MASK_W'(ALL_CORES), average_load: '0,
                                      action: ACT_ALL_UP, changed_core: '0};
                        state_next = ST_DONE;
                    end else if (!en_reg) begin
                        res_next  = '{online_mask: MASK_W'(mask_reg), average_load: '0,
                                      action: ACT_NONE, changed_core: '0};
                        state_next = ST_DONE;
                    end else begin
                        if (down_reg < DOWN_WAIT_TICKS) begin
                            down_next = down_reg + 1'b1;
                        end
                        if (up_reg < UP_WAIT_TICKS) begin
                            up_next = up_reg + 1'b1;
                        end
                        sum_next   = '0;
                        cnt_next   = '0;
                        idx_next   = '0;
                        state_next = ST_SUM;
                    end
                end
            end
            ST_SUM: begin
                if (mask_reg[idx_reg]) begin
                    sum_next = sum_reg + SUM_W'(load_sel(item_reg, idx_reg));
                    cnt_next = cnt_reg + 1'b1;
                end
                idx_next = idx_reg + 1'b1;
                if (idx_reg == IDX_W'(NUM_CORES - 1)) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                res_next = '{online_mask: MASK_W'(mask_reg), average_load: avg,
                             action: ACT_NONE, changed_core: '0};
                if (avg >= thr_reg && up_reg >= UP_WAIT_TICKS) begin
                    if (up_found) begin
                        mask_next = mask_reg | (NUM_CORES'(1) << up_idx);
                        down_next = '0;
                        up_next   = '0;
                        res_next.online_mask  = MASK_W'(mask_reg | (NUM_CORES'(1) << up_idx));
                        res_next.action       = ACT_UP;
                        res_next.changed_core = up_idx;
                    end
                end else if (down_reg >= DOWN_WAIT_TICKS) begin
                    if (cnt_reg != minc_reg && dn_found) begin
                        mask_next = mask_reg & ~(NUM_CORES'(1) << dn_idx);
                        down_next = '0;
                        up_next   = '0;
                        res_next.online_mask  = MASK_W'(mask_reg & ~(NUM_CORES'(1) << dn_idx));
                        res_next.action       = ACT_DOWN;
                        res_next.changed_core = dn_idx;
                    end
                end
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_item_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mask_reg    <= ALL_CORES;
            down_reg    <= '0;
            up_reg      <= '0;
            thr_reg     <= THRESHOLD_RESET;
            minc_reg    <= MIN_CORES_RESET;
            en_reg      <= 1'b1;
            m_valid_reg <= 1'b0;
            idx_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            mask_reg    <= mask_next;
            down_reg    <= down_next;
            up_reg      <= up_next;
            thr_reg     <= thr_next;
            minc_reg    <= minc_next;
            en_reg      <= en_next;
            m_valid_reg <= m_valid_next;
            idx_reg     <= idx_next;
        end
        item_reg   <= item_next;
        sum_reg    <= sum_next;
        cnt_reg    <= cnt_next;
        res_reg    <= res_next;
        m_item_reg <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

`default_nettype wire

### dv/cpu_hotplug_load_governor_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// cpu_hotplug_load_governor_tb: self-checking bench for the hotplug governor
// A queue-fed driver sends tick and bring-all-up items while a monitor checks
// every result against an in-bench model of the mask and hold counters.
// Register settings change between phases, only while the block is idle.
// ============================================================================

module cpu_hotplug_load_governor_tb;
    import chlg_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [0:0] CMD_ALL_UP    = 1'b1;
    localparam int         SETTLE_CYCLES = 40;
    localparam int         STALL_LIMIT   = 5000;

    typedef enum int {MODE_LOW, MODE_HIGH, MODE_NEAR, MODE_ANY} load_mode_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_valid   = 1'b0;
    logic                   s_ready;
    in_item_t               s_item    = '0;
    logic                   m_valid;
    logic                   m_ready   = 1'b0;
    out_item_t              m_item;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // Governor state and registers as the bench expects them.
    logic [MASK_W-1:0]     gov_mask;
    logic [DOWN_CNT_W-1:0] gov_down;
    logic [UP_CNT_W-1:0]   gov_up;
    logic [LOAD_W-1:0]     gov_thr;
    logic [2:0]            gov_min;
    logic                  gov_en;

    in_item_t  tick_queue[$];
    out_item_t expected_results[$];

    logic steady      = 1'b0;
    logic sender_hold = 1'b0;
    logic timed_out   = 1'b0;
    int   stall_cycles    = 0;
    int   err_count       = 0;
    int   items_sent      = 0;
    int   results_checked = 0;
    int   cfg_writes      = 0;

    cpu_hotplug_load_governor uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 aclk = ~aclk;

    function automatic void reset_governor();
        gov_mask = ALL_CORES;
        gov_down = '0;
        gov_up   = '0;
        gov_thr  = THRESHOLD_RESET;
        gov_min  = MIN_CORES_RESET;
        gov_en   = 1'b1;
    endfunction

    function automatic void apply_register(input logic [CFG_INDEX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_THRESHOLD: begin
                gov_thr = data;
            end
            CFG_MIN_CORES: begin
                gov_min  = data[2:0];
                gov_mask = ALL_CORES;
                gov_down = '0;
            end
            CFG_ENABLE: begin
                if (gov_en && !data[0]) begin
                    gov_mask = ALL_CORES;
                    gov_down = '0;
                end
                gov_en = data[0];
            end
            default: begin
            end
        endcase
    endfunction

    function automatic out_item_t predict_governor(input in_item_t it);
        out_item_t         r;
        logic [9:0]        sum;
        logic [2:0]        n;
        logic [LOAD_W-1:0] avg;
        logic              done;
        r    = '0;
        done = 1'b0;
        if (it.command != CMD_TICK) begin
            gov_mask = ALL_CORES;
            gov_down = '0;
            r.action = ACT_ALL_UP;
        end else if (gov_en) begin
            if (gov_down < DOWN_WAIT_TICKS) gov_down = gov_down + 4'd1;
            if (gov_up < UP_WAIT_TICKS) gov_up = gov_up + 2'd1;
            sum = '0;
            n   = '0;
            if (gov_mask[0]) begin sum = sum + it.load_core0; n = n + 3'd1; end
            if (gov_mask[1]) begin sum = sum + it.load_core1; n = n + 3'd1; end
            if (gov_mask[2]) begin sum = sum + it.load_core2; n = n + 3'd1; end
            if (gov_mask[3]) begin sum = sum + it.load_core3; n = n + 3'd1; end
            avg = (n != 0) ? 7'(sum / n) : '0;
            r.average_load = avg;
            if (avg >= gov_thr && gov_up >= UP_WAIT_TICKS) begin
                if (n != NUM_CORES) begin
                    for (int i = 1; i < NUM_CORES; i++) begin
                        if (!done && !gov_mask[i]) begin
                            gov_mask[i]    = 1'b1;
                            gov_down       = '0;
                            gov_up         = '0;
                            r.action       = ACT_UP;
                            r.changed_core = 2'(i);
                            done           = 1'b1;
                        end
                    end
                end
            end else if (gov_down >= DOWN_WAIT_TICKS) begin
                if (n != gov_min) begin
                    for (int i = 1; i < NUM_CORES; i++) begin
                        if (!done && gov_mask[i]) begin
                            gov_mask[i]    = 1'b0;
                            gov_down       = '0;
                            gov_up         = '0;
                            r.action       = ACT_DOWN;
                            r.changed_core = 2'(i);
                            done           = 1'b1;
                        end
                    end
                end
            end
        end
        r.online_mask = gov_mask;
        return r;
    endfunction

    function automatic logic [LOAD_W-1:0] pick_load(input load_mode_t mode);
        int lo;
        int hi;
        case (mode)
            MODE_LOW:  return 7'($urandom_range(0, 15));
            MODE_HIGH: return 7'($urandom_range(60, 127));
            MODE_NEAR: begin
                lo = (gov_thr > 3) ? gov_thr - 3 : 0;
                hi = (gov_thr < 124) ? gov_thr + 3 : 127;
                return 7'($urandom_range(lo, hi));
            end
            default: begin
                case ($urandom_range(9))
                    0:       return '0;
                    1:       return 7'd127;
                    default: return 7'($urandom_range(0, 127));
                endcase
            end
        endcase
    endfunction

    task automatic queue_item(input logic cmd, input int l0, input int l1,
                              input int l2, input int l3);
        in_item_t it;
        it.command    = cmd;
        it.load_core0 = 7'(l0);
        it.load_core1 = 7'(l1);
        it.load_core2 = 7'(l2);
        it.load_core3 = 7'(l3);
        tick_queue.push_back(it);
    endtask

    task automatic wait_idle();
        while (tick_queue.size() != 0 || s_valid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        apply_register(idx, data);
        cfg_writes++;
    endtask

    task automatic run_random_phase(input int count);
        load_mode_t mode;
        int         left;
        int         burst;
        left = count;
        while (left > 0) begin
            mode  = load_mode_t'($urandom_range(3));
            burst = $urandom_range(4, 24);
            for (int k = 0; k < burst && left > 0; k++) begin
                queue_item($urandom_range(99) < 4, pick_load(mode), pick_load(mode),
                           pick_load(mode), pick_load(mode));
                left--;
            end
        end
        // Hold the sender halfway until the block has drained completely.
        while (tick_queue.size() > count / 2) @(posedge aclk);
        sender_hold = 1'b1;
        while (s_valid || expected_results.size() != 0) @(posedge aclk);
        sender_hold = 1'b0;
        wait_idle();
    endtask

    // Driver: the head of the queue is presented and dropped once accepted.
    always @(posedge aclk) begin
        logic send;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_results.push_back(predict_governor(tick_queue.pop_front()));
                items_sent++;
            end
            if (!s_valid || s_ready) begin
                send = tick_queue.size() != 0 && !sender_hold &&
                       (steady || $urandom_range(99) >= 24);
                s_valid <= send;
                if (send) s_item <= tick_queue[0];
            end
        end
    end

    // Monitor: every accepted result is checked against the oldest prediction.
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("Result %h arrived with no item outstanding.", m_item);
                    err_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (m_item.online_mask !== want.online_mask) begin
                        $error("online_mask: expected %h, got %h",
                               want.online_mask, m_item.online_mask);
                        err_count++;
                    end
                    if (m_item.average_load !== want.average_load) begin
                        $error("average_load: expected %0d, got %0d",
                               want.average_load, m_item.average_load);
                        err_count++;
                    end
                    if (m_item.action !== want.action) begin
                        $error("action: expected %0d, got %0d", want.action, m_item.action);
                        err_count++;
                    end
                    if (m_item.changed_core !== want.changed_core) begin
                        $error("changed_core: expected %0d, got %0d",
                               want.changed_core, m_item.changed_core);
                        err_count++;
                    end
                    results_checked++;
                end
            end
            m_ready <= steady || $urandom_range(99) >= 24;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        reset_governor();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        fork
            begin
                queue_item(CMD_ALL_UP, 127, 127, 127, 127);
                for (int k = 0; k < 10; k++) queue_item(CMD_TICK, 0, 0, 0, 0);
                queue_item(CMD_TICK, 0, 127, 0, 0);
                queue_item(CMD_TICK, 127, 127, 127, 127);
                queue_item(CMD_TICK, 127, 127, 127, 127);
                queue_item(CMD_TICK, 127, 127, 127, 127);
                queue_item(CMD_TICK, 127, 0, 127, 0);
                queue_item(CMD_TICK, 0, 127, 0, 127);
                queue_item(CMD_TICK, 100, 100, 100, 100);
                queue_item(CMD_ALL_UP, 0, 0, 0, 0);
                queue_item(CMD_TICK, 24, 25, 25, 25);
                queue_item(CMD_TICK, 25, 25, 25, 25);
                queue_item(CMD_ALL_UP, 85, 42, 21, 106);
                wait_idle();

                run_random_phase(150);

                write_register(CFG_THRESHOLD, 7'd0);
                write_register(CFG_MIN_CORES, 7'd1);
                steady = 1'b1;
                run_random_phase(200);
                steady = 1'b0;

                write_register(CFG_THRESHOLD, 7'd100);
                write_register(CFG_MIN_CORES, 7'd4);
                run_random_phase(200);

                write_register(CFG_THRESHOLD, 7'd127);
                write_register(CFG_MIN_CORES, 7'd0);
                run_random_phase(200);

                write_register(CFG_UNUSED, 7'd127);
                write_register(CFG_THRESHOLD, 7'd50);
                write_register(CFG_MIN_CORES, 7'd7);
                run_random_phase(200);

                write_register(CFG_ENABLE, 7'd0);
                run_random_phase(100);
                write_register(CFG_ENABLE, 7'd0);
                write_register(CFG_ENABLE, 7'd1);
                write_register(CFG_ENABLE, 7'd1);
                run_random_phase(200);

                write_register(CFG_THRESHOLD, 7'd25);
                write_register(CFG_MIN_CORES, 7'd3);
                run_random_phase(100);
            end
            begin
                wait (stall_cycles >= STALL_LIMIT);
                timed_out = 1'b1;
                $error("No handshake for %0d cycles; stopping the run.", STALL_LIMIT);
            end
        join_any
        disable fork;

        if (expected_results.size() != 0) begin
            $error("%0d results never arrived.", expected_results.size());
            err_count++;
        end
        $display("Sent %0d items and checked %0d results across %0d register writes.",
                 items_sent, results_checked, cfg_writes);
        $display("Settings covered thresholds 0 to 127, minimum counts 0 to 7 and disabled ticks.");
        if (!timed_out && err_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
